// File: sv/pbe_pkg.sv
// Shared types and constants of the PackBits encoder.
// No dependencies; imported by pbe_ctrl, pbe_datapath and packbits_encoder.
package pbe_pkg;

    // Longest run or literal stretch that one header codes (2 to 128)
    localparam int MAX_LEN = 32;
    // Width of the group length register and of the coded bytes
    localparam int LEN_W   = 8;
    localparam int BYTE_W  = 8;
    // Width of an index into the literal memory
    localparam int IDX_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

    localparam logic [BYTE_W-1:0] END_MARK = 8'd128;
    localparam logic [8:0]        RUN_BASE = 9'd257;

    // Group phase codes
    localparam logic [1:0] PH_EMPTY = 2'd0;
    localparam logic [1:0] PH_ONE   = 2'd1;
    localparam logic [1:0] PH_RUN   = 2'd2;
    localparam logic [1:0] PH_LIT   = 2'd3;

    // Source of an emitted byte
    localparam logic [1:0] SRC_HDR  = 2'd0;
    localparam logic [1:0] SRC_MEM  = 2'd1;
    localparam logic [1:0] SRC_TAIL = 2'd2;
    localparam logic [1:0] SRC_MARK = 2'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              end_of_stream;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last_of_burst;
    } t_out_item;

    // Controller to datapath
    typedef struct packed {
        logic       load;     // take the input transaction, update group state
        logic       rd_clr;   // point the literal read at entry zero
        logic       rd_inc;   // step the literal read
        logic       emit;     // load the output register
        logic [1:0] src;
        logic       grp;      // 0 group closed by the byte, 1 end-of-stream flush
        logic       last;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic g1_en;
        logic g2_en;
        logic mark_en;
        logic cur_has_mem;
        logic cur_tail_en;
        logic mem_done;
        logic slot_free;
    } t_status;

endpackage

// File: sv/pbe_ctrl.sv
// Burst sequencer of the PackBits encoder.
// Depends on pbe_pkg; drives the command struct of pbe_datapath.
module pbe_ctrl
    import pbe_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_st,
    output t_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_HDR   = 3'd2;
    localparam logic [2:0] S_MEM   = 3'd3;
    localparam logic [2:0] S_TAIL  = 3'd4;
    localparam logic [2:0] S_MARK  = 3'd5;

    logic [2:0] r_state, n_state;
    logic       r_grp, n_grp;
    logic [2:0] after_state;
    logic       after_grp;

    assign o_in_ready = (r_state == S_IDLE);

    // Where to go once the current group is out
    always_comb begin
        after_grp = r_grp;
        if (!r_grp && i_st.g2_en) begin
            after_state = S_HDR;
            after_grp   = 1'b1;
        end else if (i_st.mark_en) begin
            after_state = S_MARK;
        end else begin
            after_state = S_IDLE;
        end
    end

    always_comb begin
        n_state = r_state;
        n_grp   = r_grp;
        o_cmd   = '0;
        o_cmd.grp = r_grp;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_START;
                end
            end
            S_START: begin
                o_cmd.rd_clr = 1'b1;
                if (i_st.g1_en) begin
                    n_state = S_HDR;
                    n_grp   = 1'b0;
                end else if (i_st.g2_en) begin
                    n_state = S_HDR;
                    n_grp   = 1'b1;
                end else if (i_st.mark_en) begin
                    n_state = S_MARK;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_HDR: begin
                if (i_st.slot_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.src  = SRC_HDR;
                    if (i_st.cur_has_mem) begin
                        n_state = S_MEM;
                    end else if (i_st.cur_tail_en) begin
                        n_state = S_TAIL;
                    end else begin
                        n_state = after_state;
                        n_grp   = after_grp;
                    end
                end
            end
            S_MEM: begin
                if (i_st.slot_free) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.src    = SRC_MEM;
                    o_cmd.rd_inc = 1'b1;
                    if (i_st.mem_done) begin
                        if (i_st.cur_tail_en) begin
                            n_state = S_TAIL;
                        end else begin
                            n_state = after_state;
                            n_grp   = after_grp;
                        end
                    end
                end
            end
            S_TAIL: begin
                if (i_st.slot_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.src  = SRC_TAIL;
                    n_state    = after_state;
                    n_grp      = after_grp;
                end
            end
            S_MARK: begin
                if (i_st.slot_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.src  = SRC_MARK;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        o_cmd.last = (n_state == S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_grp   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_grp   <= n_grp;
        end
    end

endmodule

// File: sv/pbe_datapath.sv
// Group state, literal memory, burst plan and output register of the encoder.
// Depends on pbe_pkg; commanded by pbe_ctrl.
module pbe_datapath
    import pbe_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_item,
    input  t_cmd      i_cmd,
    output t_status   o_st,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out
);

    typedef struct packed {
        logic              en;
        logic [BYTE_W-1:0] hdr;
        logic [IDX_W-1:0]  cnt;     // bytes read from the literal memory
        logic              tail_en;
        logic [BYTE_W-1:0] tail;
    } t_group;

    // Group state
    logic [1:0]        r_phase, n_phase;
    logic [BYTE_W-1:0] r_rep, n_rep;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [BYTE_W-1:0] r_last, n_last;   // newest byte of the pending group

    // Literal memory: entries 0 .. len-2 of a literal, the newest byte sits in r_last
    logic [BYTE_W-1:0] r_mem [MAX_LEN];
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [IDX_W-1:0]  r_rd_idx, rd_addr;
    logic [BYTE_W-1:0] r_rd_q;

    // Burst plan
    t_group r_g1, r_g2, n_g1, n_g2, cur;
    logic   r_mark, n_mark;

    logic              r_out_valid;
    t_out_item         r_out;
    logic [BYTE_W-1:0] emit_byte;

    logic [LEN_W-1:0]  len_c, len_e;
    logic [BYTE_W-1:0] b;

    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] n);
        logic [LEN_W-1:0] r;
        r = n;
        if (n < LEN_W'(2)) begin
            r = LEN_W'(2);
        end else if (n > LEN_W'(MAX_LEN)) begin
            r = LEN_W'(MAX_LEN);
        end
        return r;
    endfunction

    function automatic logic [BYTE_W-1:0] run_hdr(input logic [LEN_W-1:0] n);
        return BYTE_W'(RUN_BASE - 9'(n));
    endfunction

    assign b     = i_item.data_byte;
    assign len_c = clamp_len(r_len);

    always_comb begin
        n_phase = r_phase;
        n_rep   = r_rep;
        n_len   = r_len;
        n_last  = r_last;
        wr_en   = 1'b0;
        wr_addr = '0;
        n_g1    = '0;
        n_g2    = '0;
        n_mark  = 1'b0;
        len_e   = '0;
        case (r_phase)
            PH_EMPTY: begin
                n_last  = b;
                n_len   = LEN_W'(1);
                n_phase = PH_ONE;
            end
            PH_ONE: begin
                if (b == r_last) begin
                    n_rep   = b;
                    n_len   = LEN_W'(2);
                    n_phase = PH_RUN;
                end else begin
                    wr_en   = 1'b1;
                    n_last  = b;
                    n_len   = LEN_W'(2);
                    n_phase = PH_LIT;
                end
            end
            PH_RUN: begin
                if (b == r_rep && len_c < LEN_W'(MAX_LEN)) begin
                    n_len = len_c + LEN_W'(1);
                end else begin
                    n_g1.en      = 1'b1;
                    n_g1.hdr     = run_hdr(len_c);
                    n_g1.tail_en = 1'b1;
                    n_g1.tail    = r_rep;
                    n_last       = b;
                    n_len        = LEN_W'(1);
                    n_phase      = PH_ONE;
                end
            end
            PH_LIT: begin
                if (b == r_last) begin
                    // Literal minus its newest byte goes out; that byte and b form a run
                    n_g1.en  = 1'b1;
                    n_g1.hdr = BYTE_W'(len_c - LEN_W'(2));
                    n_g1.cnt = IDX_W'(len_c - LEN_W'(1));
                    n_rep    = b;
                    n_len    = LEN_W'(2);
                    n_phase  = PH_RUN;
                end else if (len_c < LEN_W'(MAX_LEN)) begin
                    wr_en   = 1'b1;
                    wr_addr = IDX_W'(len_c - LEN_W'(1));
                    n_last  = b;
                    n_len   = len_c + LEN_W'(1);
                end else begin
                    n_g1.en      = 1'b1;
                    n_g1.hdr     = BYTE_W'(len_c - LEN_W'(1));
                    n_g1.cnt     = IDX_W'(len_c - LEN_W'(1));
                    n_g1.tail_en = 1'b1;
                    n_g1.tail    = r_last;
                    n_last       = b;
                    n_len        = LEN_W'(1);
                    n_phase      = PH_ONE;
                end
            end
            default: begin
                n_phase = PH_EMPTY;
            end
        endcase

        if (i_item.end_of_stream) begin
            len_e        = clamp_len(n_len);
            n_g2.tail_en = 1'b1;
            case (n_phase)
                PH_ONE: begin
                    n_g2.en   = 1'b1;
                    n_g2.tail = n_last;
                end
                PH_RUN: begin
                    n_g2.en   = 1'b1;
                    n_g2.hdr  = run_hdr(len_e);
                    n_g2.tail = n_rep;
                end
                PH_LIT: begin
                    n_g2.en   = 1'b1;
                    n_g2.hdr  = BYTE_W'(len_e - LEN_W'(1));
                    n_g2.cnt  = IDX_W'(len_e - LEN_W'(1));
                    n_g2.tail = n_last;
                end
                default: begin
                    n_g2.tail_en = 1'b0;
                end
            endcase
            n_mark  = 1'b1;
            n_phase = PH_EMPTY;
            n_len   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_EMPTY;
            r_rep   <= '0;
            r_len   <= '0;
            r_g1    <= '0;
            r_g2    <= '0;
            r_mark  <= 1'b0;
        end else if (i_cmd.load) begin
            r_phase <= n_phase;
            r_rep   <= n_rep;
            r_len   <= n_len;
            r_g1    <= n_g1;
            r_g2    <= n_g2;
            r_mark  <= n_mark;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_last <= n_last;
        end
    end

    // Literal memory: write on a taken transaction, registered read
    always_comb begin
        rd_addr = r_rd_idx;
        if (i_cmd.rd_clr) begin
            rd_addr = '0;
        end else if (i_cmd.rd_inc) begin
            rd_addr = r_rd_idx + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && wr_en) begin
            r_mem[wr_addr] <= r_last;
        end
        r_rd_q <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx <= '0;
        end else begin
            r_rd_idx <= rd_addr;
        end
    end

    assign cur = i_cmd.grp ? r_g2 : r_g1;

    always_comb begin
        case (i_cmd.src)
            SRC_HDR:  emit_byte = cur.hdr;
            SRC_MEM:  emit_byte = r_rd_q;
            SRC_TAIL: emit_byte = cur.tail;
            SRC_MARK: emit_byte = END_MARK;
            default:  emit_byte = END_MARK;
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.out_byte      <= emit_byte;
            r_out.last_of_burst <= i_cmd.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign o_st.g1_en       = r_g1.en;
    assign o_st.g2_en       = r_g2.en;
    assign o_st.mark_en     = r_mark;
    assign o_st.cur_has_mem = (cur.cnt != '0);
    assign o_st.cur_tail_en = cur.tail_en;
    assign o_st.mem_done    = (r_rd_idx == cur.cnt - IDX_W'(1));
    assign o_st.slot_free   = !r_out_valid || i_out_ready;

endmodule

// File: sv/packbits_encoder.sv
// Top level of the PackBits run-length encoder.
// Depends on pbe_pkg, pbe_ctrl and pbe_datapath.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-----------------------------------
//  input    | in        | i_valid / o_ready  | i_data : data_byte, end_of_stream
//  output   | out       | o_valid / i_ready  | o_data : out_byte, last_of_burst
//
// Sequence: an item is taken, then dispatched, which also primes the literal
//   memory read, then its coded bytes go out (none for most bytes inside a run
//   or literal). The single output register moves one coded byte per cycle
//   while i_ready does not stall it, which sets the length of a flush.
// Reset: synchronous and active low; the group state returns to empty. The
//   literal memory is not cleared: only written entries are ever read.
// Stalls: a low i_ready holds the sequencer on the byte in the output register;
//   o_ready stays low until the last coded byte of the current item has been
//   loaded into the output register, so the next transaction may overlap it.
module packbits_encoder
    import pbe_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_data
);

    t_cmd    cmd;
    t_status st;

    // Sequencer: takes one transaction, then walks header, memory bytes, tail
    // and end marker of the planned burst
    pbe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .o_in_ready (o_ready),
        .i_st       (st),
        .o_cmd      (cmd)
    );

    // Datapath: group state update and burst plan on a taken transaction,
    // literal memory and output register
    pbe_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_data),
        .i_cmd       (cmd),
        .o_st        (st),
        .o_out_valid (o_valid),
        .i_out_ready (i_ready),
        .o_out       (o_data)
    );

endmodule
